// ===== hdl/fpr_pkg.sv =====
// Package for the framed packet receiver: shared constants, status codes and types.
// Used by every module and interface of the block; depends on nothing.
package fpr_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned WordW  = 16;
	localparam int unsigned SumW   = 15;
	localparam int unsigned StatW  = 3;
	localparam int unsigned CfgIdxW = 2;

	// Frame delimiters as little-endian words and the checksum mask
	localparam logic [WordW-1:0] HeaderWord  = 16'hA2A0;
	localparam logic [WordW-1:0] TrailerWord = 16'hB3B0;
	localparam logic [WordW-1:0] SumMask     = 16'h7FFF;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgExpectedType = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgMinLength    = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgMaxPayload   = 2'd2;

	// Reset values of the configuration registers
	localparam logic [ByteW-1:0] ExpectedTypeRst = 8'd3;
	localparam logic [WordW-1:0] MinLengthRst    = 16'd0;
	localparam logic [WordW-1:0] MaxPayloadRst   = 16'hFFFF;

	// Frame status codes
	typedef enum logic [StatW-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_HDR   = 3'd1,
		ST_SHORT     = 3'd2,
		ST_BAD_TYPE  = 3'd3,
		ST_CHECKSUM  = 3'd4,
		ST_BAD_TRAIL = 3'd5
	} status_t;

	typedef struct packed {
		logic [ByteW-1:0] expected_type;
		logic [WordW-1:0] min_length;
		logic [WordW-1:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             is_payload;
		logic             frame_end;
		logic [StatW-1:0] status;
	} res_t;

endpackage

// ===== hdl/fpr_rx_if.sv =====
// Receive byte channel: valid/ready handshake carrying one serial byte.
// Depends on fpr_pkg.
interface fpr_rx_if;
	logic                       valid;
	logic                       ready;
	logic [fpr_pkg::ByteW-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/fpr_tx_if.sv =====
// Result channel: valid/ready handshake carrying payload bytes and frame status.
// Depends on fpr_pkg.
interface fpr_tx_if;
	logic                       valid;
	logic                       ready;
	logic [fpr_pkg::ByteW-1:0]  out_byte;
	logic                       is_payload;
	logic                       frame_end;
	logic [fpr_pkg::StatW-1:0]  status;

	modport source (output valid, output out_byte, output is_payload, output frame_end,
		output status, input ready);
	modport sink   (input valid, input out_byte, input is_payload, input frame_end,
		input status, output ready);
endinterface

// ===== hdl/fpr_cfg_regs.sv =====
// Configuration registers of the framed packet receiver, written through a plain port.
// Depends on fpr_pkg.
module fpr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fpr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [fpr_pkg::WordW-1:0]     cfg_data,
	output fpr_pkg::cfg_t                 cfg
);

	fpr_pkg::cfg_t cfg_q;

	// Write the addressed register; drop writes to unused indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_type <= fpr_pkg::ExpectedTypeRst;
			cfg_q.min_length    <= fpr_pkg::MinLengthRst;
			cfg_q.max_payload   <= fpr_pkg::MaxPayloadRst;
		end else if (cfg_we) begin
			case (cfg_index)
				fpr_pkg::CfgExpectedType: cfg_q.expected_type <= cfg_data[fpr_pkg::ByteW-1:0];
				fpr_pkg::CfgMinLength:    cfg_q.min_length    <= cfg_data;
				fpr_pkg::CfgMaxPayload:   cfg_q.max_payload   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/fpr_parser.sv =====
// Frame parser: phase register, length/count/checksum state and per-byte decode.
// Depends on fpr_pkg; produces at most one result per transferred byte.
module fpr_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [fpr_pkg::ByteW-1:0]  rx_byte,
	input  fpr_pkg::cfg_t              cfg,
	output logic                       res_valid,
	output fpr_pkg::res_t              res
);

	typedef enum logic [3:0] {
		PH_HDR0 = 4'd0,
		PH_HDR1 = 4'd1,
		PH_LEN0 = 4'd2,
		PH_LEN1 = 4'd3,
		PH_TYPE = 4'd4,
		PH_DATA = 4'd5,
		PH_CK0  = 4'd6,
		PH_CK1  = 4'd7,
		PH_TR0  = 4'd8,
		PH_TR1  = 4'd9
	} phase_t;

	phase_t                      phase_q, phase_d;
	logic [fpr_pkg::ByteW-1:0]   held_q, held_d;
	logic [fpr_pkg::WordW-1:0]   left_q, left_d, left_dec;
	logic [fpr_pkg::WordW-1:0]   count_q, count_d;
	logic [fpr_pkg::SumW-1:0]    sum_q, sum_d, sum_add;
	logic [fpr_pkg::WordW-1:0]   word;

	assign word     = {rx_byte, held_q};
	assign sum_add  = sum_q + fpr_pkg::SumW'(rx_byte);
	assign left_dec = left_q - fpr_pkg::WordW'(1);

	// Decode one byte against the current phase
	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		left_d    = left_q;
		count_d   = count_q;
		sum_d     = sum_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_HDR1: begin
				if (word != fpr_pkg::HeaderWord) begin
					res_valid  = 1'b1;
					res.status = fpr_pkg::ST_BAD_HDR;
					phase_d    = PH_HDR0;
				end else begin
					phase_d = PH_LEN0;
				end
			end
			PH_LEN0: begin
				held_d  = rx_byte;
				phase_d = PH_LEN1;
			end
			PH_LEN1: begin
				if (word <= cfg.min_length) begin
					res_valid  = 1'b1;
					res.status = fpr_pkg::ST_SHORT;
					phase_d    = PH_HDR0;
				end else begin
					left_d  = word;
					count_d = '0;
					sum_d   = '0;
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				sum_d  = sum_add;
				left_d = left_dec;
				if (rx_byte != cfg.expected_type) begin
					res_valid  = 1'b1;
					res.status = fpr_pkg::ST_BAD_TYPE;
					phase_d    = PH_HDR0;
				end else begin
					phase_d = (left_dec == '0) ? PH_CK0 : PH_DATA;
				end
			end
			PH_DATA: begin
				sum_d  = sum_add;
				left_d = left_dec;
				// Emit the byte unless the payload limit is reached
				if (count_q < cfg.max_payload) begin
					count_d        = count_q + fpr_pkg::WordW'(1);
					res_valid      = 1'b1;
					res.out_byte   = rx_byte;
					res.is_payload = 1'b1;
				end
				if (left_dec == '0) begin
					phase_d = PH_CK0;
				end
			end
			PH_CK0: begin
				held_d  = rx_byte;
				phase_d = PH_CK1;
			end
			PH_CK1: begin
				if (word != {1'b0, sum_q}) begin
					res_valid  = 1'b1;
					res.status = fpr_pkg::ST_CHECKSUM;
					phase_d    = PH_HDR0;
				end else begin
					phase_d = PH_TR0;
				end
			end
			PH_TR0: begin
				held_d  = rx_byte;
				phase_d = PH_TR1;
			end
			PH_TR1: begin
				res_valid  = 1'b1;
				res.status = (word != fpr_pkg::TrailerWord) ? fpr_pkg::ST_BAD_TRAIL
					: fpr_pkg::ST_OK;
				phase_d    = PH_HDR0;
			end
			default: begin
				// Hunting for the first header byte; unused phases land here too
				held_d  = rx_byte;
				phase_d = PH_HDR1;
			end
		endcase
		res.frame_end = res_valid & ~res.is_payload;
	end

	// Advance the parser state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			held_q  <= '0;
			left_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			left_q  <= left_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

endmodule

// ===== hdl/fpr_out_reg.sv =====
// Result register between the parser and the result channel.
// Depends on fpr_pkg; a new result loads while the old one is being transferred.
module fpr_out_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  fpr_pkg::res_t  res,
	input  logic           drain,
	output logic           full,
	output fpr_pkg::res_t  res_q
);

	logic full_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (load) begin
			full_q <= 1'b1;
		end else if (drain) begin
			full_q <= 1'b0;
		end
	end

	// Hold the payload until replaced
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign full = full_q;

endmodule

// ===== hdl/framed_packet_receiver_core.sv =====
// Top level of the framed packet receiver: config registers, parser, result register.
// Depends on fpr_pkg, fpr_rx_if, fpr_tx_if, fpr_cfg_regs, fpr_parser, fpr_out_reg.
//
//   channel  | kind        | payload
//   rx       | sink        | rx_byte[7:0]
//   tx       | source      | out_byte[7:0], is_payload, frame_end, status[2:0]
//   cfg      | write only  | cfg_we, cfg_index[1:0], cfg_data[15:0]
//
// One byte is taken per cycle unless tx stalls; its result, if any, shows on tx the next cycle.
// The parser state updates on the rx transfer edge and the result register
// loads on that same edge. rx is ready whenever the result register is empty
// or its result is transferred in that cycle, so a stalled tx stalls rx.
// Reset clears the parser to header hunting and the registers to their defaults.
module framed_packet_receiver_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fpr_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [fpr_pkg::WordW-1:0]    cfg_data,
	fpr_rx_if.sink                       rx,
	fpr_tx_if.source                     tx
);

	fpr_pkg::cfg_t cfg;
	fpr_pkg::res_t res, res_q;
	logic          res_valid;
	logic          full;
	logic          take;
	logic          drain;

	assign drain    = full & tx.ready;
	assign rx.ready = ~full | tx.ready;
	assign take     = rx.valid & rx.ready;

	fpr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fpr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx.rx_byte),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	fpr_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take & res_valid),
		.res    (res),
		.drain  (drain),
		.full   (full),
		.res_q  (res_q)
	);

	// Drive the result channel from the result register
	assign tx.valid      = full;
	assign tx.out_byte   = res_q.out_byte;
	assign tx.is_payload = res_q.is_payload;
	assign tx.frame_end  = res_q.frame_end;
	assign tx.status     = res_q.status;

endmodule
